FILE: rtl/core/ffa_pkg.sv
// Shared types, constants and helper functions of the first-fit heap allocator.
package ffa_pkg;

	localparam int HEAP_BYTES = 4096;
	localparam int GRAN_BYTES = 16;
	localparam int GRAN_COUNT = HEAP_BYTES / GRAN_BYTES;
	localparam int GW         = $clog2(GRAN_COUNT);
	localparam int SW         = 13;
	localparam int OW         = 12;
	localparam int NW         = SW + 1;

	localparam logic [SW-1:0] END_WORD = SW'(1);
	localparam logic [SW-1:0] HDR_OFS  = SW'(8);

	localparam logic FN_ALLOC = 1'b0;
	localparam logic FN_FREE  = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOFIT   = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	typedef struct packed {
		logic          func;
		logic [12:0]   req_bytes;
		logic [OW-1:0] user_offset_in;
	} ffa_req_t;

	typedef struct packed {
		logic [1:0]    status;
		logic [OW-1:0] user_offset_out;
	} ffa_rsp_t;

	typedef struct packed {
		logic [SW-1:0] size;
		logic [SW-1:0] payload;
	} ffa_hdr_t;

	typedef struct packed {
		logic          re;
		logic [GW-1:0] addr;
	} ffa_rd_t;

	typedef struct packed {
		logic          we;
		logic [GW-1:0] addr;
		ffa_hdr_t      data;
	} ffa_wr_t;

	typedef struct packed {
		logic          off;
		logic [GW-1:0] idx;
	} ffa_step_t;

	// Padding that brings n + 8 to a multiple of 16; only the low nibble matters.
	function automatic logic [3:0] pad16(logic [3:0] lo);
		logic [3:0] r;
		r = lo + 4'd8;
		return 4'd0 - r;
	endfunction

	// Next header index; off is set for a zero step or one that leaves the heap.
	function automatic ffa_step_t step_of(logic [GW-1:0] g, logic [SW-1:0] size);
		logic [SW-5:0] n;
		logic [GW+1:0] sum;
		ffa_step_t     s;
		n     = size[SW-1:4];
		sum   = (GW+2)'(g) + (GW+2)'(n);
		s.off = (n == '0) || (sum >= (GW+2)'(GRAN_COUNT));
		s.idx = sum[GW-1:0];
		return s;
	endfunction

	// Power-up heap: one free block over all granules but the last, then the end marker.
	function automatic ffa_hdr_t rst_hdr(logic [GW-1:0] g);
		ffa_hdr_t h;
		h = '0;
		if (g == '0) begin
			h.size    = SW'((GRAN_COUNT - 1) * GRAN_BYTES);
			h.payload = SW'((GRAN_COUNT - 1) * GRAN_BYTES - 8);
		end else if (g == GW'(GRAN_COUNT - 1)) begin
			h.size = END_WORD;
		end
		return h;
	endfunction

endpackage

FILE: rtl/core/first_fit_heap_allocator_core.sv
// Top level: command sequencer walking the block list in the header RAM.
//
// Allocate/free engine over a 4 KiB heap of 16-byte granules. A command is taken when
// start is high and busy is low; its word comes back on rsp with done high for exactly
// one cycle, and cannot be held off. Block headers are visited one at a time, through
// the header RAM's single registered read port. Allocate walks the headers until a fit
// or the end of the list; free walks to find the block, then makes two merge passes.
// busy drops in the cycle done is shown, so the next command may follow right away.
// The heap layout is ready straight out of reset with no initialization sweep.
module first_fit_heap_allocator_core import ffa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  ffa_req_t cmd,
	output logic     busy,
	output logic     done,
	output ffa_rsp_t rsp
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_WALK  = 6'b000010,
		S_SPLIT = 6'b000100,
		S_MRG0  = 6'b001000,
		S_MRGC  = 6'b010000,
		S_MRGN  = 6'b100000
	} state_t;

	state_t        state_q, state_d;
	logic          func_q;
	logic [12:0]   req_q;
	logic [OW-1:0] uoff_q;
	logic [GW-1:0] ptr_q, ptr_d;
	logic [GW-1:0] cur_q, cur_d;
	logic          cur_free_q, cur_free_d;
	logic          pass_q, pass_d;
	logic          split_q, split_d;
	logic [GW-1:0] split_addr_q, split_addr_d;
	ffa_hdr_t      split_hdr_q, split_hdr_d;
	logic          done_q;
	ffa_rsp_t      rsp_q;

	logic          latch, fin, pass_end;
	ffa_rsp_t      fin_rsp;
	ffa_rd_t       rd;
	ffa_wr_t       wr;
	ffa_hdr_t      rdata;

	ffa_step_t     stp;
	logic          is_end, is_free;
	logic [NW-1:0] need, blk, diff;
	logic          alloc_fit, uoff_hit, split_ok;
	logic [GW+2:0] s_sum;
	logic [GW-1:0] mdiff;
	logic [SW-1:0] msz;
	logic [OW-1:0] ptr_uoff;
	logic [1:0]    fail_st;

	ffa_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd     (rd),
		.wr     (wr),
		.rdata  (rdata)
	);

	// rdata always belongs to header ptr_q while walking; one step adder serves every walk
	assign stp     = step_of(ptr_q, rdata.size);
	assign is_end  = (rdata.size == END_WORD);
	assign is_free = !rdata.size[0];

	assign need      = NW'(req_q) + NW'(pad16(req_q[3:0]));
	assign blk       = need + NW'(8);
	assign alloc_fit = is_free && (NW'(rdata.payload) >= need);
	assign diff      = NW'(rdata.size) - blk;
	assign split_ok  = (NW'(rdata.size) >= blk) && (diff >= NW'(GRAN_BYTES));
	assign s_sum     = (GW+3)'(ptr_q) + (GW+3)'(blk[NW-1:4]);
	assign ptr_uoff  = OW'({ptr_q, 4'h8});
	assign uoff_hit  = (ptr_uoff == uoff_q);
	assign mdiff     = stp.idx - cur_q;
	assign msz       = SW'({mdiff, 4'h0});
	assign fail_st   = (func_q == FN_ALLOC) ? ST_NOFIT : ST_INVALID;

	always_comb begin
		state_d      = state_q;
		ptr_d        = ptr_q;
		cur_d        = cur_q;
		cur_free_d   = cur_free_q;
		pass_d       = pass_q;
		split_d      = split_q;
		split_addr_d = split_addr_q;
		split_hdr_d  = split_hdr_q;
		latch        = 1'b0;
		fin          = 1'b0;
		fin_rsp      = '0;
		pass_end     = 1'b0;
		rd           = '0;
		wr           = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					latch   = 1'b1;
					rd.re   = 1'b1;
					rd.addr = '0;
					ptr_d   = '0;
					pass_d  = 1'b0;
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				priority if (is_end) begin
					fin            = 1'b1;
					fin_rsp.status = fail_st;
					state_d        = S_IDLE;
				end else if (func_q == FN_ALLOC && alloc_fit) begin
					wr.we           = 1'b1;
					wr.addr         = ptr_q;
					wr.data.size    = SW'(blk) | SW'(1);
					wr.data.payload = req_q;
					split_d         = split_ok && (s_sum < (GW+3)'(GRAN_COUNT));
					split_addr_d    = s_sum[GW-1:0];
					split_hdr_d.size    = SW'(diff);
					split_hdr_d.payload = SW'(diff) - HDR_OFS;
					state_d         = S_SPLIT;
				end else if (func_q == FN_FREE && uoff_hit) begin
					wr.we           = 1'b1;
					wr.addr         = ptr_q;
					wr.data.size    = rdata.size & ~SW'(1);
					wr.data.payload = rdata.payload + SW'(pad16(rdata.payload[3:0]));
					state_d         = S_MRG0;
				end else if (stp.off) begin
					fin            = 1'b1;
					fin_rsp.status = fail_st;
					state_d        = S_IDLE;
				end else begin
					rd.re   = 1'b1;
					rd.addr = stp.idx;
					ptr_d   = stp.idx;
				end
			end
			S_SPLIT: begin
				wr.we                   = split_q;
				wr.addr                 = split_addr_q;
				wr.data                 = split_hdr_q;
				fin                     = 1'b1;
				fin_rsp.status          = ST_OK;
				fin_rsp.user_offset_out = ptr_uoff;
				state_d                 = S_IDLE;
			end
			S_MRG0: begin
				rd.re   = 1'b1;
				rd.addr = '0;
				ptr_d   = '0;
				state_d = S_MRGC;
			end
			S_MRGC: begin
				cur_d      = ptr_q;
				cur_free_d = is_free;
				if (stp.off) begin
					pass_end = 1'b1;
				end else begin
					rd.re   = 1'b1;
					rd.addr = stp.idx;
					ptr_d   = stp.idx;
					state_d = S_MRGN;
				end
			end
			S_MRGN: begin
				priority if (is_end) begin
					pass_end = 1'b1;
				end else if (cur_free_q && is_free) begin
					// merge the pair only if the block after the second one is reachable
					wr.we           = !stp.off;
					wr.addr         = cur_q;
					wr.data.size    = msz;
					wr.data.payload = msz - HDR_OFS;
					pass_end        = 1'b1;
				end else if (stp.off) begin
					pass_end = 1'b1;
				end else begin
					cur_d      = ptr_q;
					cur_free_d = is_free;
					rd.re      = 1'b1;
					rd.addr    = stp.idx;
					ptr_d      = stp.idx;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (pass_end) begin
			if (pass_q) begin
				fin            = 1'b1;
				fin_rsp.status = ST_OK;
				state_d        = S_IDLE;
			end else begin
				pass_d  = 1'b1;
				state_d = S_MRG0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			pass_q  <= 1'b0;
			split_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			pass_q  <= pass_d;
			split_q <= split_d;
		end
	end

	always_ff @(posedge clk) begin
		if (latch) begin
			func_q <= cmd.func;
			req_q  <= cmd.req_bytes;
			uoff_q <= cmd.user_offset_in;
		end
		if (fin) begin
			rsp_q <= fin_rsp;
		end
		ptr_q        <= ptr_d;
		cur_q        <= cur_d;
		cur_free_q   <= cur_free_d;
		split_addr_q <= split_addr_d;
		split_hdr_q  <= split_hdr_d;
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted command did not raise busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result word without a command in flight");

	a_fail_zero_ofs: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.status != ST_OK) |-> (rsp.user_offset_out == '0))
		else $error("failed command returned a nonzero offset");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		wr.we && rd.re |-> (wr.addr != rd.addr))
		else $error("header read and write hit the same granule");

endmodule

FILE: rtl/core/ffa_mem.sv
// Header RAM: one size/payload word per granule, registered read, per-entry valid bits.
module ffa_mem import ffa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  ffa_rd_t  rd,
	input  ffa_wr_t  wr,
	output ffa_hdr_t rdata
);

	ffa_hdr_t              mem_q [GRAN_COUNT];
	ffa_hdr_t              data_q;
	logic [GRAN_COUNT-1:0] valid_q;
	logic                  vld_q;
	logic [GW-1:0]         addr_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd.re) begin
			data_q <= mem_q[rd.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_q   <= 1'b0;
			addr_q  <= '0;
		end else begin
			if (wr.we) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd.re) begin
				vld_q  <= valid_q[rd.addr];
				addr_q <= rd.addr;
			end
		end
	end

	// never-written entries read back as the power-up layout
	assign rdata = vld_q ? data_q : rst_hdr(addr_q);

endmodule
